// ===== hdl/chebyshev_iir_section_cascade_unit_assert.svh =====
// Assertion macros for the IIR section cascade checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef CHEBYSHEV_IIR_SECTION_CASCADE_UNIT_ASSERT_SVH
`define CHEBYSHEV_IIR_SECTION_CASCADE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ICSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/icsc_pkg.sv =====
// Shared constants, types and saturation helpers for the IIR section cascade.
// No dependencies; used by every module of the block except icsc_ram.
package icsc_pkg;

  localparam int MAX_SECTIONS = 8;
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 32;
  localparam int DELAY_W      = 48;
  localparam int FRAC_BITS    = 28;
  localparam int GAIN_FRAC    = 24;
  localparam int GAIN_W       = 31;
  localparam int SLOTS        = 5;
  localparam int TAPS         = 4;
  localparam int COEF_DEPTH   = MAX_SECTIONS * SLOTS;
  localparam int DELAY_DEPTH  = MAX_SECTIONS * TAPS;
  localparam int COEF_AW      = $clog2(COEF_DEPTH);
  localparam int DELAY_AW     = $clog2(DELAY_DEPTH);
  localparam int SEC_W        = $clog2(MAX_SECTIONS);
  localparam int NSEC_W       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int BOP_W        = 54;
  localparam int SPLIT        = 27;
  localparam int MUL_W        = COEF_W + SPLIT + 1;
  localparam int FULL_W       = COEF_W + BOP_W + 1;
  localparam int ACC_W        = 60;
  localparam int IN_SHIFT     = FRAC_BITS + 1 - SAMPLE_W;
  localparam int FIN_SHIFT    = GAIN_FRAC + IN_SHIFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_TYPE = 3'd0,
    CFG_SECTIONS    = 3'd1,
    CFG_OUT_GAIN    = 3'd2,
    CFG_BS_R        = 3'd3,
    CFG_BS_S        = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FT_LOWPASS  = 2'd0,
    FT_HIGHPASS = 2'd1,
    FT_BANDPASS = 2'd2,
    FT_BANDSTOP = 2'd3
  } ftype_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FB,
    ST_V0,
    ST_NUM,
    ST_GAIN,
    ST_XSAT,
    ST_WB,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic lo_en;
    logic hi_en;
    logic fin_shift;
  } mac_ctrl_t;

  function automatic logic ovf_dly(input logic signed [ACC_W-1:0] v);
    return !((&v[ACC_W-1:DELAY_W-1]) || (~|v[ACC_W-1:DELAY_W-1]));
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
    if (!ovf_dly(v)) return v[DELAY_W-1:0];
    if (v[ACC_W-1]) return {1'b1, {(DELAY_W-1){1'b0}}};
    return {1'b0, {(DELAY_W-1){1'b1}}};
  endfunction

  function automatic logic ovf_smp(input logic signed [ACC_W-1:0] v);
    return !((&v[ACC_W-1:SAMPLE_W-1]) || (~|v[ACC_W-1:SAMPLE_W-1]));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
    if (!ovf_smp(v)) return v[SAMPLE_W-1:0];
    if (v[ACC_W-1]) return {1'b1, {(SAMPLE_W-1){1'b0}}};
    return {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

endpackage

// ===== hdl/icsc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module icsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/icsc_mac.sv =====
// Shared multiplier: forms floor(a * b / 2^k) from a low-half and a high-half product.
// Depends on icsc_pkg.
module icsc_mac (
  input  logic                              clk,
  input  icsc_pkg::mac_ctrl_t               ctrl,
  input  logic signed [icsc_pkg::COEF_W-1:0] op_a,
  input  logic signed [icsc_pkg::BOP_W-1:0]  op_b,
  output logic signed [icsc_pkg::ACC_W-1:0]  term
);
  import icsc_pkg::*;

  logic signed [SPLIT:0]    half_op;
  logic signed [MUL_W-1:0]  prod;
  logic signed [MUL_W-1:0]  plo_r;
  logic signed [MUL_W-1:0]  phi_r;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] full_sh;

  // The low half of b is taken unsigned, the high half signed.
  always_comb begin
    if (ctrl.lo_en) begin
      half_op = signed'({1'b0, op_b[SPLIT-1:0]});
    end else begin
      half_op = signed'({op_b[BOP_W-1], op_b[BOP_W-1:SPLIT]});
    end
    prod = op_a * half_op;
  end

  always_ff @(posedge clk) begin
    if (ctrl.lo_en) begin
      plo_r <= prod;
    end
    if (ctrl.hi_en) begin
      phi_r <= prod;
    end
  end

  always_comb begin
    full = (FULL_W'(phi_r) <<< SPLIT) + FULL_W'(plo_r);
    if (ctrl.fin_shift) begin
      full_sh = full >>> FIN_SHIFT;
    end else begin
      full_sh = full >>> FRAC_BITS;
    end
    term = full_sh[ACC_W-1:0];
  end

endmodule

// ===== hdl/chebyshev_iir_section_cascade_unit.sv =====
// IIR section cascade: runs each sample through the n sections in use, then the
// output gain; bandstop sections take extra numerator products.
// One sample is in flight at a time; a new sample is taken only once the block is idle again.
// A single shared multiplier forms every product.
// Coefficient writes are accepted only while idle. Reset (rst_n low, synchronous) clears control,
// configuration and the delay store valid bits; the coefficient table is not cleared.
module chebyshev_iir_section_cascade_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [icsc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [icsc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_mode,
  input  logic signed [icsc_pkg::SAMPLE_W-1:0]  in_sample_in,
  input  logic [2:0]                            in_coef_section,
  input  logic [2:0]                            in_coef_slot,
  input  logic signed [icsc_pkg::COEF_W-1:0]    in_coef_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [icsc_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                  out_overflow
);
  import icsc_pkg::*;

  // Configuration registers.
  ftype_t                    ftype_r;
  logic [NSEC_W-1:0]         nsec_r;
  logic [GAIN_W-1:0]         gain_r;
  logic signed [COEF_W-1:0]  bsr_r;
  logic [GAIN_W-1:0]         bss_r;

  // Sequencer.
  state_t               state_r;
  state_t               state_nxt;
  logic [SEC_W-1:0]     sec_r;
  logic [2:0]           cnt_r;
  logic [1:0]           mph_r;

  // Datapath registers.
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [DELAY_W-1:0] x_r;
  logic signed [DELAY_W-1:0] v0_r;
  logic signed [DELAY_W-1:0] wv_r [TAPS];
  logic signed [COEF_W-1:0]  cf_r [SLOTS];
  logic                      flag_r;
  logic                      rd_vld_r;
  logic [DELAY_DEPTH-1:0]    dly_vld_r;

  logic                        out_valid_r;
  logic signed [SAMPLE_W-1:0]  out_sample_r;
  logic                        out_ovf_r;

  // Control and memory signals.
  mac_ctrl_t                 mac_ctrl;
  logic signed [COEF_W-1:0]  op_a;
  logic signed [BOP_W-1:0]   op_b;
  logic signed [ACC_W-1:0]   term;
  logic                      coef_we;
  logic [COEF_AW-1:0]        coef_waddr;
  logic                      coef_re;
  logic [COEF_AW-1:0]        coef_raddr;
  logic [COEF_W-1:0]         coef_rdata;
  logic                      dly_we;
  logic [DELAY_AW-1:0]       dly_addr;
  logic [DELAY_W-1:0]        dly_wdata;
  logic                      dly_re;
  logic [DELAY_W-1:0]        dly_rdata;

  logic                      fourth;
  logic [NSEC_W-1:0]         n_eff;
  logic                      last_sec;
  logic                      fb_last;
  logic                      prod_done;
  logic                      sample_acc;
  logic                      coef_acc;
  logic                      out_free;
  logic [2:0]                ld_idx;
  logic signed [DELAY_W-1:0] v0_sat;
  logic signed [ACC_W-1:0]   num_init;

  // Fourth-order forms use all four delays; second-order forms only the first two.
  assign fourth     = (ftype_r == FT_BANDPASS) || (ftype_r == FT_BANDSTOP);
  assign n_eff      = (nsec_r > NSEC_W'(MAX_SECTIONS)) ? NSEC_W'(MAX_SECTIONS) : nsec_r;
  assign last_sec   = (NSEC_W'(sec_r) + NSEC_W'(1)) == n_eff;
  assign fb_last    = fourth ? (cnt_r == 3'd3) : (cnt_r == 3'd1);
  assign prod_done  = (mph_r == 2'd2);
  assign sample_acc = in_valid && !in_stall && !in_mode;
  assign coef_acc   = in_valid && !in_stall && in_mode;
  assign out_free   = !out_valid_r || !out_stall;
  assign ld_idx     = cnt_r - 3'd1;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ftype_r <= FT_LOWPASS;
      nsec_r  <= NSEC_W'(1);
      gain_r  <= GAIN_W'(33554432);
      bsr_r   <= '0;
      bss_r   <= GAIN_W'(536870912);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FILTER_TYPE: ftype_r <= ftype_t'(cfg_data[1:0]);
        CFG_SECTIONS:    nsec_r  <= cfg_data[NSEC_W-1:0];
        CFG_OUT_GAIN:    gain_r  <= cfg_data[GAIN_W-1:0];
        CFG_BS_R:        bsr_r   <= signed'(cfg_data[COEF_W-1:0]);
        CFG_BS_S:        bss_r   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Next state. Each multiply state steps through three phases: low half,
  // high half, then accumulate or store the term.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sample_acc) begin
          state_nxt = (n_eff == '0) ? ST_FIN : ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (cnt_r == 3'(SLOTS)) state_nxt = ST_FB;
      end
      ST_FB: begin
        if (prod_done && fb_last) state_nxt = ST_V0;
      end
      ST_V0: begin
        state_nxt = (ftype_r == FT_BANDSTOP) ? ST_NUM : ST_GAIN;
      end
      ST_NUM: begin
        if (prod_done && (cnt_r == 3'd2)) state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        if (prod_done) state_nxt = ST_XSAT;
      end
      ST_XSAT: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (fb_last) state_nxt = last_sec ? ST_FIN : ST_LOAD;
      end
      ST_FIN: begin
        if (prod_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier operands and control, memory ports.
  always_comb begin
    mac_ctrl.lo_en     = 1'b0;
    mac_ctrl.hi_en     = 1'b0;
    mac_ctrl.fin_shift = (state_r == ST_FIN);
    op_a               = cf_r[0];
    op_b               = BOP_W'(x_r);
    coef_re            = 1'b0;
    dly_re             = 1'b0;
    dly_we             = 1'b0;
    dly_wdata          = v0_r;
    in_stall           = (state_r != ST_IDLE);
    unique case (state_r)
      ST_LOAD: begin
        coef_re = (cnt_r < 3'(SLOTS));
        dly_re  = (cnt_r < 3'(TAPS));
      end
      ST_FB: begin
        op_a = cf_r[cnt_r + 3'd1];
        op_b = BOP_W'(wv_r[cnt_r[1:0]]);
      end
      ST_NUM: begin
        op_a = (cnt_r == 3'd1) ? signed'({1'b0, bss_r}) : bsr_r;
        op_b = BOP_W'(wv_r[cnt_r[1:0]]);
      end
      ST_GAIN: begin
        op_a = cf_r[0];
        op_b = acc_r[BOP_W-1:0];
      end
      ST_FIN: begin
        op_a = signed'({1'b0, gain_r});
        op_b = BOP_W'(x_r);
      end
      ST_WB: begin
        dly_we    = 1'b1;
        dly_wdata = (cnt_r == 3'd0) ? v0_r : wv_r[cnt_r[1:0] - 2'd1];
      end
      default: begin
      end
    endcase
    if (state_r == ST_FB || state_r == ST_NUM || state_r == ST_GAIN || state_r == ST_FIN) begin
      mac_ctrl.lo_en = (mph_r == 2'd0);
      mac_ctrl.hi_en = (mph_r == 2'd1);
    end
  end

  assign coef_we    = coef_acc && (in_coef_slot < 3'(SLOTS));
  assign coef_waddr = COEF_AW'(in_coef_section) * COEF_AW'(SLOTS) + COEF_AW'(in_coef_slot);
  assign coef_raddr = COEF_AW'(sec_r) * COEF_AW'(SLOTS) + COEF_AW'(cnt_r);
  assign dly_addr   = {sec_r, cnt_r[1:0]};

  // Section output before the gain product: v0 plus the fixed numerator taps.
  always_comb begin
    v0_sat = sat_dly(acc_r);
    unique case (ftype_r)
      FT_LOWPASS:  num_init = ACC_W'(v0_sat) + (ACC_W'(wv_r[0]) <<< 1) + ACC_W'(wv_r[1]);
      FT_HIGHPASS: num_init = ACC_W'(v0_sat) - (ACC_W'(wv_r[0]) <<< 1) + ACC_W'(wv_r[1]);
      FT_BANDPASS: num_init = ACC_W'(v0_sat) - (ACC_W'(wv_r[1]) <<< 1) + ACC_W'(wv_r[3]);
      FT_BANDSTOP: num_init = ACC_W'(v0_sat) + ACC_W'(wv_r[3]);
      default:     num_init = ACC_W'(v0_sat);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Counters, phase and delay valid bits (control state).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r     <= '0;
      cnt_r     <= '0;
      mph_r     <= '0;
      dly_vld_r <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          sec_r <= '0;
          cnt_r <= '0;
          mph_r <= '0;
        end
        ST_LOAD: begin
          cnt_r <= (cnt_r == 3'(SLOTS)) ? 3'd0 : cnt_r + 3'd1;
        end
        ST_FB: begin
          mph_r <= prod_done ? 2'd0 : mph_r + 2'd1;
          if (prod_done) cnt_r <= fb_last ? 3'd0 : cnt_r + 3'd1;
        end
        ST_NUM: begin
          mph_r <= prod_done ? 2'd0 : mph_r + 2'd1;
          if (prod_done) cnt_r <= (cnt_r == 3'd2) ? 3'd0 : cnt_r + 3'd1;
        end
        ST_GAIN, ST_FIN: begin
          mph_r <= prod_done ? 2'd0 : mph_r + 2'd1;
        end
        ST_V0, ST_XSAT: begin
          cnt_r <= '0;
        end
        ST_WB: begin
          dly_vld_r[dly_addr] <= 1'b1;
          cnt_r <= fb_last ? 3'd0 : cnt_r + 3'd1;
          if (fb_last && !last_sec) sec_r <= sec_r + SEC_W'(1);
        end
        ST_OUT: begin
          cnt_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (dly_re) begin
      rd_vld_r <= dly_vld_r[dly_addr];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (sample_acc) begin
          x_r    <= DELAY_W'(in_sample_in) <<< IN_SHIFT;
          acc_r  <= '0;
          flag_r <= 1'b0;
        end
      end
      ST_LOAD: begin
        if (cnt_r != 3'd0) begin
          cf_r[ld_idx] <= signed'(coef_rdata);
          if (ld_idx < 3'(TAPS)) begin
            wv_r[ld_idx[1:0]] <= rd_vld_r ? signed'(dly_rdata) : '0;
          end
        end
        if (cnt_r == 3'(SLOTS)) acc_r <= ACC_W'(x_r);
      end
      ST_FB: begin
        if (prod_done) acc_r <= acc_r + term;
      end
      ST_V0: begin
        v0_r   <= v0_sat;
        flag_r <= flag_r | ovf_dly(acc_r);
        acc_r  <= num_init;
      end
      ST_NUM: begin
        if (prod_done) acc_r <= (cnt_r == 3'd1) ? acc_r + term : acc_r - term;
      end
      ST_GAIN, ST_FIN: begin
        if (prod_done) acc_r <= term;
      end
      ST_XSAT: begin
        x_r    <= sat_dly(acc_r);
        flag_r <= flag_r | ovf_dly(acc_r);
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished beat may wait here while the next sample comes in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_sample_r <= sat_smp(acc_r);
      out_ovf_r    <= flag_r | ovf_smp(acc_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_overflow   = out_ovf_r;

  icsc_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_we),
    .wr_addr (coef_waddr),
    .wr_data (in_coef_value),
    .rd_en   (coef_re),
    .rd_addr (coef_raddr),
    .rd_data (coef_rdata)
  );

  icsc_ram #(.WIDTH(DELAY_W), .DEPTH(DELAY_DEPTH)) u_dly_ram (
    .clk     (clk),
    .wr_en   (dly_we),
    .wr_addr (dly_addr),
    .wr_data (dly_wdata),
    .rd_en   (dly_re),
    .rd_addr (dly_addr),
    .rd_data (dly_rdata)
  );

  icsc_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .term (term)
  );

endmodule

// ===== hdl/icsc_chk.sv =====
// Port-level checker for the IIR section cascade, bound to the top level.
// Depends on icsc_pkg and the assertion macro header.
`include "chebyshev_iir_section_cascade_unit_assert.svh"

module icsc_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 in_mode,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [icsc_pkg::SAMPLE_W-1:0] out_sample_out
);

  // A stalled result beat holds.
  `ICSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample_out), "result beat changed under stall")

  // A sample keeps the block busy in the following cycle.
  `ICSC_ASSERT_NEXT(a_busy_after_sample, in_valid && !in_stall && !in_mode, in_stall, "sample accepted without going busy")

  // A coefficient write leaves the input free in the following cycle.
  `ICSC_ASSERT_NEXT(a_coef_single, in_valid && !in_stall && in_mode, !in_stall, "coefficient write stalled the input")

  // While idle, no new result can appear once the pending one is taken.
  `ICSC_ASSERT_NEXT(a_no_spurious, out_valid && !out_stall && !in_stall, !out_valid, "result produced while idle")

endmodule

bind chebyshev_iir_section_cascade_unit icsc_chk u_icsc_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for chebyshev_iir_section_cascade_unit.
// Depends on the block's RTL and on icsc_pkg for widths, register indexes and filter types.
`timescale 1ns / 1ps

module tb;
  import icsc_pkg::*;

  // Wide signed arithmetic for the cascade model: the largest product here
  // is a 32-bit coefficient times a 54-bit value, so 128 bits are ample.
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       ovf;
  } filt_result_t;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;
  localparam logic [2:0] SLOT_GAIN = 3'd0;
  localparam logic [2:0] SLOT_LAST = 3'd4;
  localparam int DRAIN_CYCLES = 320;   // covers the block's worst-case latency
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = MODE_SAMPLE;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic [2:0] in_coef_section = '0;
  logic [2:0] in_coef_slot = '0;
  logic signed [COEF_W-1:0] in_coef_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic out_overflow;

  chebyshev_iir_section_cascade_unit u_top (.*);

  always #5 clk = ~clk;

  // Shadow state of the block: configuration, coefficient table and delay line.
  ftype_t mdl_ftype;
  int     mdl_sections;
  wide_t  mdl_gain, mdl_bs_r, mdl_bs_s;
  wide_t  mdl_coef [COEF_DEPTH];
  wide_t  mdl_dly  [DELAY_DEPTH];

  filt_result_t pending_results[$];
  int     err_count = 0;
  longint cycle_count = 0;
  int     stall_pct = 0;   // receiver stall probability in percent
  int     gap_pct = 0;     // chance of a sender gap after each beat
  int     gap_max = 1;

  function automatic wide_t mul_floor(input wide_t a, input wide_t b, input int k);
    wide_t p;
    p = a * b;
    return p >>> k;
  endfunction

  function automatic wide_t clamp(input wide_t v, input int w, inout bit hit);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Runs one sample through the shadow cascade and queues the expected result.
  function automatic void predict_sample(input logic signed [SAMPLE_W-1:0] s);
    bit hit;
    int n;
    bit fourth;
    wide_t x, acc, v0, num, y;
    filt_result_t r;
    hit = 1'b0;
    x = wide_t'(s) <<< IN_SHIFT;
    n = (mdl_sections > MAX_SECTIONS) ? MAX_SECTIONS : mdl_sections;
    fourth = (mdl_ftype == FT_BANDPASS) || (mdl_ftype == FT_BANDSTOP);
    for (int i = 0; i < n; i++) begin
      acc = x + mul_floor(mdl_coef[i*5+1], mdl_dly[i*4], FRAC_BITS)
              + mul_floor(mdl_coef[i*5+2], mdl_dly[i*4+1], FRAC_BITS);
      if (fourth)
        acc = acc + mul_floor(mdl_coef[i*5+3], mdl_dly[i*4+2], FRAC_BITS)
                  + mul_floor(mdl_coef[i*5+4], mdl_dly[i*4+3], FRAC_BITS);
      v0 = clamp(acc, DELAY_W, hit);
      case (mdl_ftype)
        FT_LOWPASS:  num = v0 + 2 * mdl_dly[i*4] + mdl_dly[i*4+1];
        FT_HIGHPASS: num = v0 - 2 * mdl_dly[i*4] + mdl_dly[i*4+1];
        FT_BANDPASS: num = v0 - 2 * mdl_dly[i*4+1] + mdl_dly[i*4+3];
        default:     num = v0 - mul_floor(mdl_bs_r, mdl_dly[i*4], FRAC_BITS)
                            + mul_floor(mdl_bs_s, mdl_dly[i*4+1], FRAC_BITS)
                            - mul_floor(mdl_bs_r, mdl_dly[i*4+2], FRAC_BITS)
                            + mdl_dly[i*4+3];
      endcase
      x = clamp(mul_floor(mdl_coef[i*5], num, FRAC_BITS), DELAY_W, hit);
      if (fourth) begin
        mdl_dly[i*4+3] = mdl_dly[i*4+2];
        mdl_dly[i*4+2] = mdl_dly[i*4+1];
      end
      mdl_dly[i*4+1] = mdl_dly[i*4];
      mdl_dly[i*4]   = v0;
    end
    y = clamp(mul_floor(mdl_gain, x, FIN_SHIFT), SAMPLE_W, hit);
    r.sample = y[SAMPLE_W-1:0];
    r.ovf = hit;
    pending_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    err_count++;
    $display("MISMATCH %s: expected %0d, got %0d (cycle %0d)", what, want, got, cycle_count);
  endtask

  // Result checker: every beat on the output is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat, sample", 0, out_sample_out);
      end else begin
        filt_result_t e;
        e = pending_results.pop_front();
        if (out_sample_out !== e.sample) report_mismatch("sample_out", e.sample, out_sample_out);
        if (out_overflow !== e.ovf) report_mismatch("overflow", e.ovf, out_overflow);
      end
    end
  end

  // The receiver stalls on its own random pattern, set per test.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sends one beat and waits until it is accepted. Valid stays high afterwards so
  // that back-to-back beats form a burst; a gap lowers it at the next falling edge.
  task automatic send_beat(input logic mode, input logic signed [SAMPLE_W-1:0] s,
                           input logic [2:0] sec, input logic [2:0] slot,
                           input logic signed [COEF_W-1:0] val);
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_sample_in <= s;
    in_coef_section <= sec;
    in_coef_slot <= slot;
    in_coef_value <= val;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (mode == MODE_COEF) begin
      if (slot <= SLOT_LAST) mdl_coef[sec*5 + slot] = wide_t'(val);
    end else begin
      predict_sample(s);
    end
    if ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
    end
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    send_beat(MODE_SAMPLE, s, 3'($urandom), 3'($urandom), $urandom);
  endtask

  task automatic send_coef(input logic [2:0] sec, input logic [2:0] slot,
                           input logic signed [COEF_W-1:0] val);
    send_beat(MODE_COEF, 16'($urandom), sec, slot, val);
  endtask

  // Waits for every expected result, then for the block's worst-case latency,
  // since a trailing coefficient write leaves nothing to wait for.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    drain_block();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_FILTER_TYPE: mdl_ftype = ftype_t'(data[1:0]);
      CFG_SECTIONS:    mdl_sections = data[3:0];
      CFG_OUT_GAIN:    mdl_gain = wide_t'({1'b0, data[30:0]});
      CFG_BS_R:        mdl_bs_r = wide_t'($signed(data));
      default:         mdl_bs_s = wide_t'({1'b0, data[30:0]});
    endcase
  endtask

  // Mostly moderate coefficients so the cascade does not pin at its rails,
  // with the odd full-range word to exercise saturation.
  function automatic logic signed [COEF_W-1:0] pick_coef(input logic [2:0] slot);
    if ($urandom_range(0, 4) == 0) return $urandom;
    if (slot == SLOT_GAIN) return $urandom_range(0, 32'h1000_0000);
    return $signed($urandom_range(0, 32'h0C00_0000)) - 32'sh0600_0000;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Fills every coefficient so that no read of an unwritten entry can happen,
  // whatever the section count is later set to.
  task automatic test_load_table();
    for (int s = 0; s < MAX_SECTIONS; s++)
      for (int k = 0; k <= SLOT_LAST; k++)
        send_coef(3'(s), 3'(k), pick_coef(3'(k)));
  endtask

  // Directed part: reset defaults, sample extremes, ignored slots, every filter
  // form, zero and excessive section counts, and a type change with kept delays.
  task automatic test_directed();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_coef(3'd2, 3'd5, 32'sh7FFF_FFFF);   // ignored slots
    send_coef(3'd7, 3'd7, 32'sh8000_0000);
    send_sample(16'sh4000);
    write_reg(CFG_SECTIONS, 32'd0);           // only the output gain applies
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    write_reg(CFG_SECTIONS, 32'd15);          // clipped to eight sections
    write_reg(CFG_OUT_GAIN, 32'h7FFF_FFFF);
    send_sample(16'sh0100);
    send_sample(16'sh8000);
    write_reg(CFG_FILTER_TYPE, FT_HIGHPASS);
    send_sample(16'sh1234);
    write_reg(CFG_FILTER_TYPE, FT_BANDPASS);
    write_reg(CFG_OUT_GAIN, 32'd0);
    send_sample(16'sh7FFF);
    write_reg(CFG_FILTER_TYPE, FT_BANDSTOP);
    write_reg(CFG_BS_R, 32'h8000_0000);
    write_reg(CFG_BS_S, 32'hFFFF_FFFF);
    write_reg(CFG_OUT_GAIN, 32'h0200_0000);
    send_sample(16'sh2000);
    send_sample(16'shC000);
    write_reg(CFG_FILTER_TYPE, FT_LOWPASS);   // delays survive the change
    send_sample(16'sh0001);
  endtask

  // Random phases: each sets a fresh configuration, then streams samples with
  // coefficient rewrites mixed in. Idling settings change from phase to phase.
  task automatic test_random_phases();
    int produced;
    int phase;
    produced = 0;
    phase = 0;
    while (produced < 560) begin
      case (phase % 4)
        0: begin stall_pct = 0;  gap_pct = 0;  end
        1: begin stall_pct = 30; gap_pct = 20; gap_max = 6; end
        2: begin stall_pct = 70; gap_pct = 50; gap_max = 40; end
        default: begin stall_pct = $urandom_range(0, 90); gap_pct = $urandom_range(0, 60); end
      endcase
      write_reg(CFG_FILTER_TYPE, $urandom_range(0, 3));
      write_reg(CFG_SECTIONS, (phase == 0) ? 32'd8 : $urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_OUT_GAIN, (phase % 2) ? 32'h7FFF_FFFF : 32'd0);
        1: write_reg(CFG_OUT_GAIN, $urandom);
        default: write_reg(CFG_OUT_GAIN, $urandom_range(32'h0080_0000, 32'h0800_0000));
      endcase
      write_reg(CFG_BS_R, $urandom_range(0, 1) ? $urandom : pick_coef(3'd1));
      write_reg(CFG_BS_S, $urandom);
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          logic [2:0] slot;
          slot = 3'($urandom);
          send_coef(3'($urandom), slot, pick_coef(slot));
          if (slot <= SLOT_LAST) produced++;
        end else begin
          send_sample(pick_sample());
          produced++;
        end
        // Now and then the sender holds off until the block has caught up.
        if (i == 30 && phase % 3 == 1) drain_block();
      end
      phase++;
    end
  endtask

  initial begin
    mdl_ftype = FT_LOWPASS;
    mdl_sections = 1;
    mdl_gain = 33554432;
    mdl_bs_r = 0;
    mdl_bs_s = 536870912;
    foreach (mdl_dly[i]) mdl_dly[i] = 0;
    foreach (mdl_coef[i]) mdl_coef[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_load_table();
    test_directed();
    test_random_phases();
    drain_block();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
